// ===== rtl/bmp_stream_decoder_top_macros.svh =====
// Assertion macros for the BMP stream decoder.
// Used by bmp_stream_decoder_top; expects clk and rst_n in scope.
`ifndef BMP_STREAM_DECODER_TOP_MACROS_SVH
`define BMP_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsd_pkg.sv =====
// Shared constants, result codes and structs for the BMP stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int PALETTE_ENTRIES = 256;

    localparam int HDR_BYTES = 54;
    localparam int INFO_SIZE = 40;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int COLOR_W   = 24;

    localparam logic [15:0] SIGNATURE = 16'h4D42; // "BM", little-endian

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_SIGNATURE = 3'd0;
    localparam logic [2:0] ERR_INFO_SIZE = 3'd1;
    localparam logic [2:0] ERR_PLANES    = 3'd2;
    localparam logic [2:0] ERR_DEPTH     = 3'd3;
    localparam logic [2:0] ERR_DIMENSION = 3'd4;
    localparam logic [2:0] ERR_OFFSET    = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [12:0] width;
        logic [12:0] height;
        logic        last;
        logic        pal_sel;   // color comes from the palette read
    } bsd_result_t;

    typedef struct packed {
        logic                en;
        logic [PAL_AW-1:0]   addr;
        logic [COLOR_W-1:0]  data;
    } bsd_wr_t;

endpackage

// ===== rtl/bsd_palette_ram.sv =====
// Palette memory: 256 x 24 (B | G<<8 | R<<16), one write and one
// registered read port. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_palette_ram
    import bsd_pkg::*;
(
    input  logic               clk,
    input  bsd_wr_t            wr,
    input  logic               rd_en,
    input  logic [PAL_AW-1:0]  rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bsd_ctrl.sv =====
// Byte parser: header checks, palette load, gap skip and pixel walk.
// Drives the palette write and read ports. Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_ctrl
    import bsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         file_byte,
    input  logic               end_of_file,
    output bsd_result_t        res,
    output bsd_wr_t            wr,
    output logic               rd_en,
    output logic [PAL_AW-1:0]  rd_addr
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_GAP     = 3'd2;
    localparam logic [2:0] PH_PIXELS  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  hdr_idx_reg, hdr_idx_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] pix_start_reg, pix_start_next;
    logic [12:0] cols_reg, cols_next;
    logic [12:0] rows_reg, rows_next;
    logic        paletted_reg, paletted_next;
    logic [8:0]  pal_count_reg, pal_count_next;
    logic [14:0] row_idx_reg, row_idx_next;
    logic [12:0] rows_done_reg, rows_done_next;
    logic [15:0] held_reg, held_next;
    logic [1:0]  mod3_reg, mod3_next;   // byte position within a B,G,R triple

    logic [31:0] word_shift;
    logic [31:0] pos_inc;
    logic [14:0] data_len;
    logic [14:0] row_len;
    logic [14:0] k_inc;
    logic        last_px;
    logic [10:0] pal_off;
    logic [10:0] pal_end;
    logic [8:0]  cnt9;
    logic [10:0] need;

    assign word_shift = {file_byte, word_reg[31:8]};
    assign pos_inc    = pos_reg + 32'd1;
    assign data_len   = paletted_reg ? {2'b00, cols_reg}
                                     : ({2'b00, cols_reg} + {1'b0, cols_reg, 1'b0});
    assign row_len    = (data_len + 15'd3) & ~15'd3;
    assign k_inc      = row_idx_reg + 15'd1;
    assign last_px    = (({1'b0, rows_done_reg} + 14'd1) == {1'b0, rows_reg})
                        && (k_inc == data_len);
    assign pal_off    = pos_reg[10:0] - 11'(HDR_BYTES);
    assign pal_end    = 11'(HDR_BYTES) + {pal_count_reg, 2'b00};
    assign cnt9       = (word_shift == 32'd0) ? 9'(PAL_DEPTH) : word_shift[8:0];
    assign need       = paletted_reg ? (11'(HDR_BYTES) + {cnt9, 2'b00}) : 11'(HDR_BYTES);

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        pix_start_next = pix_start_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        paletted_next  = paletted_reg;
        pal_count_next = pal_count_reg;
        row_idx_next   = row_idx_reg;
        rows_done_next = rows_done_reg;
        held_next      = held_reg;
        mod3_next      = mod3_reg;
        res            = '0;
        wr             = '0;
        rd_en          = 1'b0;
        rd_addr        = file_byte;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    word_next    = word_shift;
                    hdr_idx_next = hdr_idx_reg + 6'd1;
                    pos_next     = pos_inc;
                    unique case (hdr_idx_reg)
                        6'd1:
                        begin
                            if (word_shift[31:16] != SIGNATURE)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_SIGNATURE;
                            end
                        end
                        6'd13:
                        begin
                            pix_start_next = word_shift;
                        end
                        6'd17:
                        begin
                            if (word_shift != 32'(INFO_SIZE))
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_INFO_SIZE;
                            end
                        end
                        6'd21:
                        begin
                            cols_next = (word_shift >= 32'd1 && word_shift <= 32'(MAX_WIDTH))
                                        ? word_shift[12:0] : 13'd0;
                        end
                        6'd25:
                        begin
                            rows_next = (word_shift >= 32'd1 && word_shift <= 32'(MAX_HEIGHT))
                                        ? word_shift[12:0] : 13'd0;
                        end
                        6'd27:
                        begin
                            if (word_shift[31:16] != 16'd1)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_PLANES;
                            end
                        end
                        6'd29:
                        begin
                            if (word_shift[31:16] == 16'd24)
                            begin
                                paletted_next = 1'b0;
                            end
                            else if (word_shift[31:16] == 16'd8)
                            begin
                                paletted_next = 1'b1;
                            end
                            if (word_shift[31:16] != 16'd24 && word_shift[31:16] != 16'd8)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_DEPTH;
                            end
                            else if (cols_reg == 13'd0 || rows_reg == 13'd0)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_DIMENSION;
                            end
                        end
                        6'd49:
                        begin
                            pal_count_next = paletted_reg ? cnt9 : 9'd0;
                            if (paletted_reg && word_shift > 32'(PALETTE_ENTRIES))
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_DEPTH;
                            end
                            else if (pix_start_reg < {21'd0, need})
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_ERROR;
                                res.code  = ERR_OFFSET;
                            end
                        end
                        6'd53:
                        begin
                            if (paletted_reg)
                            begin
                                phase_next = PH_PALETTE;
                            end
                            else
                            begin
                                phase_next = (pos_inc == pix_start_reg) ? PH_PIXELS : PH_GAP;
                            end
                            res.valid  = 1'b1;
                            res.kind   = KIND_HEADER;
                            res.width  = cols_reg;
                            res.height = rows_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (res.valid && res.kind == KIND_ERROR)
                    begin
                        phase_next = PH_ERROR;
                    end
                end

                PH_PALETTE:
                begin
                    unique case (pal_off[1:0])
                        2'd0:    word_next = {24'd0, file_byte};
                        2'd1:    word_next = word_reg | {16'd0, file_byte, 8'd0};
                        2'd2:
                        begin
                            wr.en   = 1'b1;
                            wr.addr = pal_off[9:2];
                            wr.data = {file_byte, word_reg[15:0]};
                        end
                        default:
                        begin
                        end
                    endcase
                    pos_next = pos_inc;
                    if (pos_inc == {21'd0, pal_end})
                    begin
                        phase_next = (pos_inc == pix_start_reg) ? PH_PIXELS : PH_GAP;
                    end
                end

                PH_GAP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc == pix_start_reg)
                    begin
                        phase_next = PH_PIXELS;
                    end
                end

                PH_PIXELS:
                begin
                    if (row_idx_reg < data_len)
                    begin
                        if (paletted_reg)
                        begin
                            // index beyond the loaded count reads as black
                            res.valid   = 1'b1;
                            res.kind    = KIND_PIXEL;
                            res.last    = last_px;
                            res.pal_sel = ({1'b0, file_byte} < pal_count_reg);
                            rd_en       = res.pal_sel;
                        end
                        else
                        begin
                            unique case (mod3_reg)
                                2'd0:    held_next = {8'd0, file_byte};
                                2'd1:    held_next = {file_byte, held_reg[7:0]};
                                default:
                                begin
                                    res.valid = 1'b1;
                                    res.kind  = KIND_PIXEL;
                                    res.blue  = held_reg[7:0];
                                    res.green = held_reg[15:8];
                                    res.red   = file_byte;
                                    res.last  = last_px;
                                end
                            endcase
                            mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                        end
                    end
                    if (row_idx_reg < data_len && last_px)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (k_inc >= row_len)
                    begin
                        row_idx_next   = 15'd0;
                        rows_done_next = rows_done_reg + 13'd1;
                        mod3_next      = 2'd0;
                    end
                    else
                    begin
                        row_idx_next = k_inc;
                    end
                end

                default:
                begin
                end
            endcase

            if (end_of_file)
            begin
                // truncation replaces whatever this byte gave, unless it finished or failed
                if (phase_next != PH_DONE && phase_next != PH_ERROR)
                begin
                    res       = '0;
                    res.valid = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.code  = ERR_TRUNCATED;
                end
                phase_next     = PH_HEADER;
                hdr_idx_next   = '0;
                pos_next       = '0;
                word_next      = '0;
                pix_start_next = '0;
                cols_next      = '0;
                rows_next      = '0;
                paletted_next  = 1'b0;
                pal_count_next = '0;
                row_idx_next   = '0;
                rows_done_next = '0;
                held_next      = '0;
                mod3_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            pos_reg       <= '0;
            word_reg      <= '0;
            pix_start_reg <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            paletted_reg  <= 1'b0;
            pal_count_reg <= '0;
            row_idx_reg   <= '0;
            rows_done_reg <= '0;
            held_reg      <= '0;
            mod3_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            pos_reg       <= pos_next;
            word_reg      <= word_next;
            pix_start_reg <= pix_start_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            paletted_reg  <= paletted_next;
            pal_count_reg <= pal_count_next;
            row_idx_reg   <= row_idx_next;
            rows_done_reg <= rows_done_next;
            held_reg      <= held_next;
            mod3_reg      <= mod3_next;
        end
    end

endmodule

// ===== rtl/bmp_stream_decoder_top.sv =====
// Top level of the streaming BMP decoder (8-bit paletted and 24-bit).
// Depends on bsd_pkg, bsd_ctrl, bsd_palette_ram, bmp_stream_decoder_top_macros.svh.
//
//  channel   | dir | tdata                  | tuser        | tlast
//  ----------+-----+------------------------+--------------+-------------
//  s_axis    | in  | file_byte              | -            | end_of_file
//  m_axis    | out | code,B,G,R,width,height| result_kind  | last_pixel
//
// One file byte per cycle while m_axis_tready keeps up; the only per-byte work is counter
// updates and at most one palette read or write.
// A result passes through the read stage, where the synchronous palette
// read completes, and then into the output register.
// Reset clears parser state and the valid flags only; the palette needs no
// clearing pass, as only entries loaded for the current file are ever read.
// With m_axis_tready low, one result waits in the output register and one
// in the read stage; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
`include "bmp_stream_decoder_top_macros.svh"

module bmp_stream_decoder_top
    import bsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] error_code, [10:3] blue, [18:11] green,
                                        // [26:19] red, [39:27] width_out,
                                        // [52:40] height_out, [55:53] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // last_pixel
);

    // byte accepted into the parser
    logic               in_xfer;
    bsd_result_t        res;
    bsd_wr_t            pal_wr;
    logic               pal_rd_en;
    logic [PAL_AW-1:0]  pal_rd_addr;
    logic [COLOR_W-1:0] pal_rd_data;

    // read stage: waits for the palette data
    logic               s2_valid_reg, s2_valid_next;
    bsd_result_t        s2_reg;
    logic               s2_move;

    // output register
    logic               out_valid_reg, out_valid_next;
    bsd_result_t        out_reg;
    bsd_result_t        out_next;

    assign s2_move       = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s2_valid_reg || s2_move;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    bsd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_xfer),
        .file_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .res         (res),
        .wr          (pal_wr),
        .rd_en       (pal_rd_en),
        .rd_addr     (pal_rd_addr)
    );

    bsd_palette_ram u_palette (
        .clk     (clk),
        .wr      (pal_wr),
        .rd_en   (pal_rd_en),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    assign s2_valid_next  = (in_xfer && res.valid) || (s2_valid_reg && !s2_move);
    assign out_valid_next = s2_move || (out_valid_reg && !m_axis_tready);

    // palette color merges in here; read data holds while the stage stalls
    always_comb
    begin
        out_next = s2_reg;
        if (s2_reg.pal_sel)
        begin
            out_next.blue  = pal_rd_data[7:0];
            out_next.green = pal_rd_data[15:8];
            out_next.red   = pal_rd_data[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && res.valid)
        begin
            s2_reg <= res;
        end
        if (s2_move)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {3'b000, out_reg.height, out_reg.width, out_reg.red,
                            out_reg.green, out_reg.blue, out_reg.code};

    // an empty read stage always takes a byte
    `BSD_ASSERT_IMP(a_empty_ready, !s2_valid_reg, s_axis_tready, "ready low with empty read stage")
    // a blocked output keeps the read stage's result
    `BSD_ASSERT_NXT(a_s2_hold, s2_valid_reg && out_valid_reg && !m_axis_tready, s2_valid_reg, "read stage result lost")
    // last_pixel only on pixels
    `BSD_ASSERT_IMP(a_last_is_pixel, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_PIXEL, "last flag on non-pixel")
    // errors carry no color
    `BSD_ASSERT_IMP(a_err_black, m_axis_tvalid && m_axis_tuser == KIND_ERROR, m_axis_tdata[26:3] == 24'd0, "color on error")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bmp_stream_decoder_top: whole BMP files go in byte by byte and
// every result is checked against a fixed expectation or a byte-level decoder model kept here.
// Depends on bsd_pkg and the decoder RTL only.

module testbench;
    import bsd_pkg::*;

    localparam int CYCLE_LIMIT      = 3000000;
    localparam int RANDOM_BYTES     = 350;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int MAX_IDLE         = 14;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_PALETTE,
        ST_GAP,
        ST_PIXELS,
        ST_DONE,
        ST_FAILED
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [12:0] width;
        logic [12:0] height;
        logic        last;
    } decode_result_t;

    // One file to send: header fields, layout of the body, and where to cut it short.
    // A typed row carries its one expected result; other rows go through the model.
    typedef struct {
        logic [15:0]    sig;
        logic [31:0]    info_size;
        logic [15:0]    planes;
        logic [15:0]    bit_count;
        logic [31:0]    width;
        logic [31:0]    height;
        logic [31:0]    colors_used;
        int             gap;
        bit             fixed_offset;
        logic [31:0]    offset;
        int             trail;
        int             cut_at;     // 0 whole file, -1 random cut, else length kept
        bit             typed;
        decode_result_t want;
    } bmp_file_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    bmp_stream_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    decode_result_t expected_results[$];
    logic [7:0]     file_bytes[$];
    bmp_file_t      directed_files[$];
    int             mismatches = 0;
    int             cycles = 0;
    bit             tx_quiet = 1'b0;
    bit             rx_quiet = 1'b0;

    // Decoder model state
    parse_state_t st;
    logic [5:0]   hdr_idx;
    logic [31:0]  pos;
    logic [31:0]  word;
    logic [31:0]  data_start;
    logic [12:0]  cols;
    logic [12:0]  rows;
    logic         indexed;
    logic [8:0]   ncolors;
    logic [23:0]  color_table [256];
    logic [14:0]  row_byte;
    logic [12:0]  rows_seen;
    logic [15:0]  held;

    function automatic void restart_parser();
        st         = ST_HEADER;
        hdr_idx    = '0;
        pos        = '0;
        word       = '0;
        data_start = '0;
        cols       = '0;
        rows       = '0;
        indexed    = 1'b0;
        ncolors    = '0;
        row_byte   = '0;
        rows_seen  = '0;
        held       = '0;
    endfunction

    function automatic decode_result_t error_result(logic [2:0] code);
        decode_result_t r;
        r      = '0;
        r.kind = KIND_ERROR;
        r.code = code;
        return r;
    endfunction

    // Advances the model by one file byte; returns 1 when the byte gives a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic eof,
                                       output decode_result_t r);
        int          i;
        int          k;
        int          data_len;
        int          row_len;
        logic [31:0] w;
        logic [31:0] p;
        logic [63:0] need;
        logic [63:0] cnt;
        logic [23:0] c;
        bit          got;
        bit          last_px;
        r   = '0;
        got = 1'b0;
        case (st)
            ST_HEADER:
            begin
                i       = hdr_idx;
                word    = {b, word[31:8]};
                w       = word;
                hdr_idx = hdr_idx + 6'd1;
                pos     = pos + 1;
                // each field is taken on its last byte; dimension and offset checks wait for later fields
                if (i == 1)
                begin
                    if (w[31:16] != SIGNATURE)
                    begin
                        st = ST_FAILED; r = error_result(ERR_SIGNATURE); got = 1'b1;
                    end
                end
                else if (i == 13)
                    data_start = w;
                else if (i == 17)
                begin
                    if (w != INFO_SIZE)
                    begin
                        st = ST_FAILED; r = error_result(ERR_INFO_SIZE); got = 1'b1;
                    end
                end
                else if (i == 21)
                    cols = (w >= 1 && w <= MAX_WIDTH) ? w[12:0] : 13'd0;
                else if (i == 25)
                    rows = (w >= 1 && w <= MAX_HEIGHT) ? w[12:0] : 13'd0;
                else if (i == 27)
                begin
                    if (w[31:16] != 16'd1)
                    begin
                        st = ST_FAILED; r = error_result(ERR_PLANES); got = 1'b1;
                    end
                end
                else if (i == 29)
                begin
                    if (w[31:16] == 16'd24)
                        indexed = 1'b0;
                    else if (w[31:16] == 16'd8)
                        indexed = 1'b1;
                    else
                    begin
                        st = ST_FAILED; r = error_result(ERR_DEPTH); got = 1'b1;
                    end
                    if (st != ST_FAILED && (cols == 0 || rows == 0))
                    begin
                        st = ST_FAILED; r = error_result(ERR_DIMENSION); got = 1'b1;
                    end
                end
                else if (i == 49)
                begin
                    need = HDR_BYTES;
                    if (indexed)
                    begin
                        cnt = (w == 0) ? 64'd256 : {32'd0, w};
                        if (cnt > PALETTE_ENTRIES)
                        begin
                            st = ST_FAILED; r = error_result(ERR_DEPTH); got = 1'b1;
                        end
                        else
                        begin
                            ncolors = cnt[8:0];
                            need    = need + 4 * cnt;
                        end
                    end
                    else
                        ncolors = '0;
                    // the stream cannot go back to an offset it has already passed
                    if (st != ST_FAILED && {32'd0, data_start} < need)
                    begin
                        st = ST_FAILED; r = error_result(ERR_OFFSET); got = 1'b1;
                    end
                end
                else if (i == 53)
                begin
                    if (indexed)
                        st = ST_PALETTE;
                    else
                        st = (pos == data_start) ? ST_PIXELS : ST_GAP;
                    r.kind   = KIND_HEADER;
                    r.width  = cols;
                    r.height = rows;
                    got      = 1'b1;
                end
            end
            ST_PALETTE:
            begin
                p = pos - HDR_BYTES;
                case (p[1:0])
                    2'd0: word = {24'd0, b};
                    2'd1: word[15:8] = b;
                    2'd2: color_table[p[9:2]] = {b, word[15:0]};
                    default: ;
                endcase
                pos = pos + 1;
                if (pos == HDR_BYTES + 4 * ncolors)
                    st = (pos == data_start) ? ST_PIXELS : ST_GAP;
            end
            ST_GAP:
            begin
                pos = pos + 1;
                if (pos == data_start)
                    st = ST_PIXELS;
            end
            ST_PIXELS:
            begin
                data_len = indexed ? int'(cols) : 3 * int'(cols);
                row_len  = (data_len + 3) & ~3;
                k        = row_byte;
                if (k < data_len)
                begin
                    last_px = (int'(rows_seen) + 1 == int'(rows)) && (k + 1 == data_len);
                    if (indexed)
                    begin
                        // indexes past the loaded palette come out black
                        c       = (b < ncolors) ? color_table[b] : 24'd0;
                        r.blue  = c[7:0];
                        r.green = c[15:8];
                        r.red   = c[23:16];
                        r.last  = last_px;
                        got     = 1'b1;
                    end
                    else
                    begin
                        case (k % 3)
                            0: held = {8'd0, b};
                            1: held[15:8] = b;
                            default:
                            begin
                                r.blue  = held[7:0];
                                r.green = held[15:8];
                                r.red   = b;
                                r.last  = last_px;
                                got     = 1'b1;
                            end
                        endcase
                    end
                    if (last_px)
                        st = ST_DONE;
                end
                if (st != ST_DONE)
                begin
                    k = k + 1;
                    if (k >= row_len)
                    begin
                        k         = 0;
                        rows_seen = rows_seen + 13'd1;
                    end
                    row_byte = k[14:0];
                end
            end
            default: ;
        endcase
        if (eof)
        begin
            // a short file is reported unless an error or the last pixel already ended it
            if (st != ST_DONE && st != ST_FAILED)
            begin
                r   = error_result(ERR_TRUNCATED);
                got = 1'b1;
            end
            restart_parser();
        end
        return got;
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int j = 0; j < n; j++)
            file_bytes.push_back(v[8*j +: 8]);
    endfunction

    function automatic bmp_file_t good_spec(logic [15:0] bit_count, logic [31:0] width,
                                            logic [31:0] height, logic [31:0] colors_used);
        bmp_file_t f;
        f.sig          = SIGNATURE;
        f.info_size    = INFO_SIZE;
        f.planes       = 16'd1;
        f.bit_count    = bit_count;
        f.width        = width;
        f.height       = height;
        f.colors_used  = colors_used;
        f.gap          = 0;
        f.fixed_offset = 1'b0;
        f.offset       = '0;
        f.trail        = 0;
        f.cut_at       = 0;
        f.typed        = 1'b0;
        f.want         = '0;
        return f;
    endfunction

    function automatic void add_error_row(bmp_file_t f, logic [2:0] code);
        f.typed = 1'b1;
        f.want  = error_result(code);
        directed_files.push_back(f);
    endfunction

    // Lays out the file in file_bytes. Only a header that passes every check gets a
    // palette, gap and pixel body; a bad one is followed by up to eight loose bytes.
    function automatic void build_file(bmp_file_t f);
        int          pal_n;
        int          data_len;
        int          row_len;
        int          keep;
        logic [31:0] off;
        bit          body;
        file_bytes.delete();
        pal_n = 0;
        if (f.bit_count == 16'd8)
            pal_n = (f.colors_used == 0) ? 256
                  : (f.colors_used > 256) ? 257 : int'(f.colors_used);
        off  = f.fixed_offset ? f.offset : HDR_BYTES + 4 * pal_n + f.gap;
        body = f.sig == SIGNATURE && f.info_size == INFO_SIZE && f.planes == 16'd1
            && (f.bit_count == 16'd8 || f.bit_count == 16'd24) && pal_n <= PALETTE_ENTRIES
            && f.width >= 1 && f.width <= MAX_WIDTH && f.height >= 1 && f.height <= MAX_HEIGHT
            && off >= HDR_BYTES + 4 * pal_n;
        put_le(f.sig, 2);
        put_le($urandom, 4);        // file size, not checked
        put_le($urandom, 4);        // reserved
        put_le(off, 4);
        put_le(f.info_size, 4);
        put_le(f.width, 4);
        put_le(f.height, 4);
        put_le(f.planes, 2);
        put_le(f.bit_count, 2);
        put_le($urandom, 4);        // compression
        put_le($urandom, 4);        // image size
        put_le($urandom, 4);        // x resolution
        put_le($urandom, 4);        // y resolution
        put_le(f.colors_used, 4);
        put_le($urandom, 4);        // important colors
        if (body)
        begin
            repeat (4 * pal_n) put_le($urandom, 1);
            while (file_bytes.size() < off)
                put_le($urandom, 1);
            data_len = (f.bit_count == 16'd8) ? int'(f.width) : 3 * int'(f.width);
            row_len  = (data_len + 3) & ~3;
            // indexes mostly hit the loaded palette, now and then go past it
            repeat (int'(f.height) * row_len)
            begin
                if (f.bit_count == 16'd8 && $urandom_range(0, 7) != 0)
                    put_le($urandom_range(0, pal_n - 1), 1);
                else
                    put_le($urandom, 1);
            end
        end
        else
            repeat ($urandom_range(0, 8)) put_le($urandom, 1);
        repeat (f.trail) put_le($urandom, 1);
        keep = (f.cut_at < 0) ? $urandom_range(1, file_bytes.size()) : f.cut_at;
        if (keep > 0)
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
    endfunction

    // Sends file_bytes, the last one marked end of file. Each accepted byte steps the
    // model; a typed row queues its own expectation instead.
    task automatic send_file(input bit typed, input decode_result_t want);
        int             gap;
        bit             got;
        decode_result_t r;
        if (typed)
            expected_results.push_back(want);
        foreach (file_bytes[n])
        begin
            if ($urandom_range(0, 99) == 0)
                tx_quiet = !tx_quiet;
            gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= file_bytes[n];
            s_axis_tlast  <= (n == file_bytes.size() - 1);
            do
                @(posedge clk);
            while (!s_axis_tready);
            got = decode_byte(file_bytes[n], n == file_bytes.size() - 1, r);
            if (got && !typed)
                expected_results.push_back(r);
        end
    endtask

    function automatic string show(decode_result_t r);
        return $sformatf("kind=%0d code=%0d bgr=%02h/%02h/%02h w=%0d h=%0d last=%0d",
                         r.kind, r.code, r.blue, r.green, r.red, r.width, r.height, r.last);
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: %s", $realtime, msg);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls on m_axis_tready, one draw per transfer.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        decode_result_t seen;
        decode_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.code   = m_axis_tdata[2:0];
            seen.blue   = m_axis_tdata[10:3];
            seen.green  = m_axis_tdata[18:11];
            seen.red    = m_axis_tdata[26:19];
            seen.width  = m_axis_tdata[39:27];
            seen.height = m_axis_tdata[52:40];
            seen.kind   = m_axis_tuser;
            seen.last   = m_axis_tlast;
            if (expected_results.size() == 0)
                log_mismatch({"unexpected result: ", show(seen)});
            else
            begin
                want = expected_results.pop_front();
                if (seen.kind !== want.kind || seen.code !== want.code
                    || seen.blue !== want.blue || seen.green !== want.green
                    || seen.red !== want.red || seen.width !== want.width
                    || seen.height !== want.height || seen.last !== want.last)
                    log_mismatch({"result mismatch: expected ", show(want),
                                  " got ", show(seen)});
            end
        end
    end

    initial
    begin
        bmp_file_t f;
        int        pick;
        int        draw;
        int        random_bytes;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        restart_parser();
        foreach (color_table[n])
            color_table[n] = '0;

        // Header failures, each with a fixed answer, grouped by error code.
        // Most files end a byte past the failing field, so the tail is ignored.
        f = good_spec(16'd24, 1, 1, 0); f.sig = 16'h4142; f.cut_at = 3;
        add_error_row(f, ERR_SIGNATURE);
        f = good_spec(16'd24, 1, 1, 0); f.sig = 16'h4142; f.cut_at = 2;  // error on the eof byte
        add_error_row(f, ERR_SIGNATURE);
        f = good_spec(16'd24, 1, 1, 0); f.info_size = 32'd12; f.cut_at = 19;
        add_error_row(f, ERR_INFO_SIZE);
        f = good_spec(16'd24, 1, 1, 0); f.planes = 16'd0; f.cut_at = 29;
        add_error_row(f, ERR_PLANES);
        f = good_spec(16'd16, 1, 1, 0); f.cut_at = 31;
        add_error_row(f, ERR_DEPTH);
        f = good_spec(16'd8, 1, 1, 257); f.cut_at = 51;
        add_error_row(f, ERR_DEPTH);
        f = good_spec(16'd24, 0, 1, 0); f.cut_at = 31;
        add_error_row(f, ERR_DIMENSION);
        f = good_spec(16'd24, 1, 32'hFFFF_FFFF, 0); f.cut_at = 31;   // top-down image
        add_error_row(f, ERR_DIMENSION);
        f = good_spec(16'd24, MAX_WIDTH + 1, 1, 0); f.cut_at = 31;
        add_error_row(f, ERR_DIMENSION);
        f = good_spec(16'd24, 1, 1, 0); f.fixed_offset = 1'b1; f.offset = HDR_BYTES - 1;
        f.cut_at = 51;
        add_error_row(f, ERR_OFFSET);
        f = good_spec(16'd8, 1, 1, 4); f.fixed_offset = 1'b1; f.offset = HDR_BYTES + 15;
        f.cut_at = 51;
        add_error_row(f, ERR_OFFSET);
        // zero count means a full palette, so this offset lands inside it
        f = good_spec(16'd8, 1, 1, 0); f.fixed_offset = 1'b1;
        f.offset = HDR_BYTES + 4 * PAL_DEPTH - 1; f.cut_at = 51;
        add_error_row(f, ERR_OFFSET);
        f = good_spec(16'd24, 2, 2, 0); f.cut_at = 20;
        add_error_row(f, ERR_TRUNCATED);
        f = good_spec(16'd24, 2, 2, 0); f.cut_at = HDR_BYTES;      // replaces the header result
        add_error_row(f, ERR_TRUNCATED);

        // Good files and short ones, checked by the model
        f = good_spec(16'd24, 1, 1, 0); f.gap = 3; f.trail = 2;
        directed_files.push_back(f);
        f = good_spec(16'd24, 4, 2, 0);
        directed_files.push_back(f);
        f = good_spec(16'd8, 3, 2, 2);                             // small palette
        directed_files.push_back(f);
        f = good_spec(16'd24, 2, 2, 0); f.cut_at = HDR_BYTES + 5;  // cut inside pixel data
        directed_files.push_back(f);
        f = good_spec(16'd8, 2, 2, 4); f.cut_at = HDR_BYTES + 6;   // cut inside the palette
        directed_files.push_back(f);
        f = good_spec(16'd24, 1, 1, 0); f.gap = 4; f.cut_at = HDR_BYTES + 2;  // cut in the gap
        directed_files.push_back(f);
        f = good_spec(16'd24, 1, 1, 0); f.cut_at = HDR_BYTES + 3;  // eof on the last pixel
        directed_files.push_back(f);
        f = good_spec(16'd24, MAX_WIDTH, 1, 0); f.cut_at = HDR_BYTES + 6;   // widest row
        directed_files.push_back(f);
        f = good_spec(16'd8, 1, MAX_HEIGHT, 2); f.cut_at = HDR_BYTES + 16;  // tallest image
        directed_files.push_back(f);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_files[n])
        begin
            build_file(directed_files[n]);
            send_file(directed_files[n].typed, directed_files[n].want);
        end

        // Random part: mostly well-formed small files, some with one bad header field,
        // some cut short, and a little plain noise.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                file_bytes.delete();
                repeat ($urandom_range(1, 70)) file_bytes.push_back(8'($urandom));
            end
            else
            begin
                draw = $urandom_range(0, 19);
                f = good_spec($urandom_range(0, 1) ? 16'd8 : 16'd24, $urandom_range(1, 12),
                              $urandom_range(1, 4),
                              (draw == 0) ? $urandom_range(17, 256) : $urandom_range(1, 16));
                f.gap   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                f.trail = $urandom_range(0, 3);
                if (pick < 20)
                begin
                    case ($urandom_range(0, 7))
                        0: f.sig = 16'($urandom);
                        1: f.info_size = $urandom_range(0, 1) ? $urandom : 32'd12;
                        2: f.planes = 16'($urandom);
                        3: f.bit_count = 16'($urandom_range(0, 32));
                        4: f.width = $urandom_range(0, 1) ? 32'd0 : $urandom;
                        5: f.height = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 9)
                                                           : MAX_HEIGHT + 1;
                        6:
                        begin
                            f.bit_count   = 16'd8;
                            f.colors_used = $urandom_range(PALETTE_ENTRIES + 1, 1000);
                        end
                        default:
                        begin
                            f.fixed_offset = 1'b1;
                            f.offset       = $urandom_range(0, HDR_BYTES - 1);
                        end
                    endcase
                end
                else if (pick < 30)
                    f.cut_at = -1;
                build_file(f);
            end
            random_bytes += file_bytes.size();
            send_file(1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bsd_pkg.sv
rtl/bsd_palette_ram.sv
rtl/bsd_ctrl.sv
rtl/bmp_stream_decoder_top.sv
test/testbench.sv
